>>> rtl/itp_pkg.sv
// Package for the infix-to-postfix converter: operator codes, item classes,
// back-end states, the queued item type and character decode functions.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [2:0] CODE_NONE  = 3'd0;
  localparam logic [2:0] CODE_POW   = 3'd1;
  localparam logic [2:0] CODE_MOD   = 3'd2;
  localparam logic [2:0] CODE_MUL   = 3'd3;
  localparam logic [2:0] CODE_DIV   = 3'd4;
  localparam logic [2:0] CODE_ADD   = 3'd5;
  localparam logic [2:0] CODE_SUB   = 3'd6;
  localparam logic [2:0] CODE_OPEN  = 3'd7;

  localparam logic [7:0] CHAR_CLOSE = 8'h29;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNMATCHED = 2'd2;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_ALNUM,
    CLS_OPER,
    CLS_OPEN,
    CLS_CLOSE
  } cls_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAIN,
    BK_FLUSH,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    cls_t       cls;
    logic [2:0] code;
    logic [7:0] ch;
    logic       last;
  } item_t;

  function automatic logic [2:0] char_to_code(input logic [7:0] ch);
    logic [2:0] code;
    unique case (ch)
      8'h5e:   code = CODE_POW;
      8'h25:   code = CODE_MOD;
      8'h2a:   code = CODE_MUL;
      8'h2f:   code = CODE_DIV;
      8'h2b:   code = CODE_ADD;
      8'h2d:   code = CODE_SUB;
      8'h28:   code = CODE_OPEN;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] code_to_char(input logic [2:0] code);
    logic [7:0] ch;
    unique case (code)
      CODE_POW:  ch = 8'h5e;
      CODE_MOD:  ch = 8'h25;
      CODE_MUL:  ch = 8'h2a;
      CODE_DIV:  ch = 8'h2f;
      CODE_ADD:  ch = 8'h2b;
      CODE_SUB:  ch = 8'h2d;
      CODE_OPEN: ch = 8'h28;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input logic [2:0] code);
    logic [1:0] prec;
    unique case (code)
      CODE_POW:                    prec = 2'd3;
      CODE_MOD, CODE_MUL, CODE_DIV: prec = 2'd2;
      CODE_ADD, CODE_SUB:          prec = 2'd1;
      default:                     prec = 2'd0;
    endcase
    return prec;
  endfunction

  function automatic logic is_alnum(input logic [7:0] ch);
    return ((ch >= 8'h41) && (ch <= 8'h5a)) || ((ch >= 8'h61) && (ch <= 8'h7a)) ||
           ((ch >= 8'h30) && (ch <= 8'h39));
  endfunction

endpackage

`default_nettype wire

>>> rtl/itp_if.sv
// Valid/ready channel interfaces of the infix-to-postfix converter.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       expr_last;

  modport source (output valid, char_in, expr_last, input ready);
  modport sink (input valid, char_in, expr_last, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       has_char;
  logic       run_last;
  logic       expr_end;
  logic [1:0] status;

  modport source (output valid, char_out, has_char, run_last, expr_end, status,
                  input ready);
  modport sink (input valid, char_out, has_char, run_last, expr_end, status,
                output ready);
endinterface

`default_nettype wire

>>> rtl/itp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/itp_front.sv
// Front end: accepts input items, classifies the character and queues the
// item for the back end. Depends on itp_pkg and itp_if.
`timescale 1ns / 1ps
`default_nettype none

module itp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  itp_in_if.sink             in_ch,
  output logic               q_valid,
  output itp_pkg::item_t     q_item,
  input  wire logic          q_ready
);

  localparam int unsigned PW = $clog2(itp_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(itp_pkg::QUEUE_DEPTH + 1);

  itp_pkg::item_t mem_r [itp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  itp_pkg::item_t cls_item;
  logic           in_fire;
  logic           enq;
  logic           deq;

  always_comb begin
    cls_item.ch   = in_ch.char_in;
    cls_item.last = in_ch.expr_last;
    cls_item.code = itp_pkg::char_to_code(in_ch.char_in);
    if (itp_pkg::is_alnum(in_ch.char_in)) begin
      cls_item.cls = itp_pkg::CLS_ALNUM;
    end else if (in_ch.char_in == itp_pkg::CHAR_CLOSE) begin
      cls_item.cls = itp_pkg::CLS_CLOSE;
    end else if (cls_item.code == itp_pkg::CODE_OPEN) begin
      cls_item.cls = itp_pkg::CLS_OPEN;
    end else if (cls_item.code != itp_pkg::CODE_NONE) begin
      cls_item.cls = itp_pkg::CLS_OPER;
    end else begin
      cls_item.cls = itp_pkg::CLS_NONE;
    end
  end

  assign in_ch.ready = (fill_r != CW'(itp_pkg::QUEUE_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;
  // An ignored character that does not end the expression has no effect.
  assign enq         = in_fire && ((cls_item.cls != itp_pkg::CLS_NONE) || cls_item.last);
  assign q_valid     = (fill_r != '0);
  assign q_item      = mem_r[rptr_r];
  assign deq         = q_valid && q_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (enq) begin
      wptr_nxt = (wptr_r == PW'(itp_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (deq) begin
      rptr_nxt = (rptr_r == PW'(itp_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (enq && !deq) begin
      fill_nxt = fill_r + CW'(1);
    end else if (!enq && deq) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/itp_back.sv
// Back end: operator stack sequencer that pops, pushes and emits postfix
// characters into the result register. Depends on itp_pkg, itp_if, itp_ram.
`timescale 1ns / 1ps
`default_nettype none

module itp_back #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire itp_pkg::item_t q_item,
  output logic               q_ready,
  itp_out_if.source          out_ch
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  itp_pkg::back_state_t state_r, state_nxt;
  itp_pkg::item_t       item_r;
  logic [1:0]           stat_r, stat_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        open_r, open_nxt;
  logic [2:0]           top_r, top_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic [7:0]           hold_ch_r, hold_ch_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_has_r, out_has_nxt;
  logic                 out_rlast_r, out_rlast_nxt;
  logic                 out_end_r, out_end_nxt;
  logic [1:0]           out_stat_r, out_stat_nxt;

  logic       out_free;
  logic       emit_room;
  logic       not_empty;
  logic       room;
  logic       want_gen;
  logic       gen;
  logic [7:0] gen_ch;
  logic       do_pop;
  logic       do_push;
  logic [2:0] push_code;
  logic       step_done;
  logic       flush_done;
  logic       fin_done;
  logic       load;
  logic       bare;
  logic [2:0] below;
  logic [AW-1:0] raddr;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit_room = !hold_v_r || out_free;
  assign not_empty = (cnt_r != '0);
  assign room      = (cnt_r != CW'(STACK_DEPTH));
  assign bare      = item_r.last || (stat_r != itp_pkg::STAT_OK);

  always_comb begin
    if (state_r != itp_pkg::BK_FIN) begin
      fin_done = 1'b0;
    end else if (hold_v_r || bare) begin
      fin_done = out_free;
    end else begin
      fin_done = 1'b1;
    end
  end

  assign load    = q_valid && ((state_r == itp_pkg::BK_IDLE) || fin_done);
  assign q_ready = load;

  always_comb begin
    stat_nxt = stat_r;
    if (load) begin
      stat_nxt = itp_pkg::STAT_OK;
      if ((q_item.cls == itp_pkg::CLS_CLOSE) && (open_r == '0)) begin
        stat_nxt = itp_pkg::STAT_UNMATCHED;
      end else if ((cnt_r == CW'(STACK_DEPTH)) &&
                   ((q_item.cls == itp_pkg::CLS_OPEN) ||
                    ((q_item.cls == itp_pkg::CLS_OPER) &&
                     (itp_pkg::code_prec(top_r) < itp_pkg::code_prec(q_item.code))))) begin
        stat_nxt = itp_pkg::STAT_OVERFLOW;
      end
    end
  end

  // Stack actions of the current step.
  always_comb begin
    want_gen   = 1'b0;
    gen_ch     = itp_pkg::code_to_char(top_r);
    do_pop     = 1'b0;
    do_push    = 1'b0;
    push_code  = item_r.code;
    step_done  = 1'b0;
    flush_done = 1'b0;
    unique case (state_r)
      itp_pkg::BK_MAIN: begin
        unique case (item_r.cls)
          itp_pkg::CLS_ALNUM: begin
            want_gen  = 1'b1;
            gen_ch    = item_r.ch;
            step_done = emit_room;
          end
          itp_pkg::CLS_OPEN: begin
            push_code = itp_pkg::CODE_OPEN;
            do_push   = room;
            step_done = 1'b1;
          end
          itp_pkg::CLS_OPER: begin
            if (not_empty &&
                (itp_pkg::code_prec(top_r) >= itp_pkg::code_prec(item_r.code))) begin
              want_gen = 1'b1;
              do_pop   = emit_room;
            end else begin
              do_push   = room;
              step_done = 1'b1;
            end
          end
          itp_pkg::CLS_CLOSE: begin
            if (!not_empty) begin
              step_done = 1'b1;
            end else if (top_r == itp_pkg::CODE_OPEN) begin
              do_pop    = 1'b1;
              step_done = 1'b1;
            end else begin
              want_gen = 1'b1;
              do_pop   = emit_room;
            end
          end
          default: begin
            step_done = 1'b1;
          end
        endcase
      end
      itp_pkg::BK_FLUSH: begin
        if (not_empty) begin
          want_gen = 1'b1;
          do_pop   = emit_room;
        end else begin
          flush_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign gen = want_gen && emit_room;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itp_pkg::BK_IDLE: begin
        if (load) begin
          state_nxt = itp_pkg::BK_MAIN;
        end
      end
      itp_pkg::BK_MAIN: begin
        if (step_done) begin
          state_nxt = item_r.last ? itp_pkg::BK_FLUSH : itp_pkg::BK_FIN;
        end
      end
      itp_pkg::BK_FLUSH: begin
        if (flush_done) begin
          state_nxt = itp_pkg::BK_FIN;
        end
      end
      itp_pkg::BK_FIN: begin
        if (fin_done) begin
          state_nxt = load ? itp_pkg::BK_MAIN : itp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = itp_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    open_nxt = open_r;
    top_nxt  = top_r;
    if (do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
      top_nxt = below;
      if (top_r == itp_pkg::CODE_OPEN) begin
        open_nxt = open_r - CW'(1);
      end
    end else if (do_push) begin
      cnt_nxt = cnt_r + CW'(1);
      top_nxt = push_code;
      if (push_code == itp_pkg::CODE_OPEN) begin
        open_nxt = open_r + CW'(1);
      end
    end
  end

  // The read port always follows the entry just below the next top.
  assign raddr = (cnt_nxt >= CW'(2)) ? AW'(cnt_nxt - CW'(2)) : '0;

  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_ch_nxt   = hold_ch_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_has_nxt   = out_has_r;
    out_rlast_nxt = out_rlast_r;
    out_end_nxt   = out_end_r;
    out_stat_nxt  = out_stat_r;
    if (gen) begin
      hold_v_nxt  = 1'b1;
      hold_ch_nxt = gen_ch;
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = hold_ch_r;
        out_has_nxt   = 1'b1;
        out_rlast_nxt = 1'b0;
        out_end_nxt   = 1'b0;
        out_stat_nxt  = stat_r;
      end
    end
    if (fin_done && (hold_v_r || bare)) begin
      hold_v_nxt    = 1'b0;
      out_valid_nxt = 1'b1;
      out_char_nxt  = hold_v_r ? hold_ch_r : 8'h00;
      out_has_nxt   = hold_v_r;
      out_rlast_nxt = 1'b1;
      out_end_nxt   = item_r.last;
      out_stat_nxt  = stat_r;
    end
  end

  itp_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (do_push),
    .waddr (AW'(cnt_r)),
    .wdata (push_code),
    .raddr (raddr),
    .rdata (below)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itp_pkg::BK_IDLE;
      cnt_r       <= '0;
      open_r      <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      open_r      <= open_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= q_item;
    end
    stat_r      <= stat_nxt;
    top_r       <= top_nxt;
    hold_ch_r   <= hold_ch_nxt;
    out_char_r  <= out_char_nxt;
    out_has_r   <= out_has_nxt;
    out_rlast_r <= out_rlast_nxt;
    out_end_r   <= out_end_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.has_char = out_has_r;
  assign out_ch.run_last = out_rlast_r;
  assign out_ch.expr_end = out_end_r;
  assign out_ch.status   = out_stat_r;

endmodule

`default_nettype wire

>>> rtl/infix_to_postfix_converter_unit.sv
// Infix-to-postfix converter, top level: front end, item queue and stack
// back end. Depends on itp_pkg, itp_if, itp_front, itp_back, itp_ram.
//
// The in_chan channel takes one expression character per item, with
// expr_last set on the final character. The out_chan channel returns the
// postfix characters; run_last marks the last result of an input item,
// expr_end the last result of the expression, status the item's status.
// The front end classifies each character and queues it in a two-entry
// queue unless it is ignored and not expr_last, so input items are taken
// while the back end is still busy. The back end handles each item in its
// main and finish states, popping and emitting stack entries as needed;
// the matching '(' of a close parenthesis is dropped within its step, and
// an item with expr_last also passes through a flush state that pops and
// emits the rest of the stack. The single stack read port allows one pop
// per cycle while the receiver takes results; a stalled receiver holds the
// result register and the back end waits while the queue fills up.
// Reset empties the stack and the queue at once, not clearing stack memory.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_unit #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  itp_in_if.sink    in_chan,
  itp_out_if.source out_chan
);

  logic           q_valid;
  logic           q_ready;
  itp_pkg::item_t q_item;

  itp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .out_ch  (out_chan)
  );

endmodule

`default_nettype wire
